[rtl/core/rhsv_pkg.sv]
// rhsv_pkg: shared types and constants for the rgb to hsv converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 16;

  localparam int DEG_SECTOR = 60;
  localparam int DEG_GREEN  = 120;
  localparam int DEG_BLUE   = 240;
  localparam int DEG_FULL   = 360;

  typedef enum logic [2:0] {
    SECT_RED   = 3'b001,
    SECT_GREEN = 3'b010,
    SECT_BLUE  = 3'b100
  } sector_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue_x64;
    logic [16:0] sat_frac;
    logic [7:0]  value_out;
  } result_t;

  // per-beat control and side data that rides along the divider row
  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    sector_t    sector;
    logic       neg;
    logic       grey;
    logic       black;
  } side_t;

endpackage

[rtl/core/rgb_to_hsv_converter.sv]
// rgb_to_hsv_converter: pixel-rate rgb to hsv conversion, top level
// depends on rhsv_pkg, rhsv_front and rhsv_div_cell
`timescale 1ns / 1ps

//  channel  ports                  beat
//  input    start, busy, pixel     start high while busy low
//  output   done, result           done high for one cycle
//
// a new pixel is taken every cycle; busy is always low
// a result passes the front register, then the row of division cells, then the done and result registers;
// QW = max(SAT_FRAC_BITS + 1, HUE_FRAC_BITS + 6) cells, one quotient bit per cell (17 cells at defaults)
// synchronous reset clears the valid bits along the row; beats in flight are dropped
// the receiver takes each result in its single done cycle
module rgb_to_hsv_converter #(
  parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhsv_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rhsv_pkg::pixel_t  pixel,
  output logic              done,
  output rhsv_pkg::result_t result
);
  import rhsv_pkg::*;

  localparam int QW = (SAT_FRAC_BITS + 1 > HUE_FRAC_BITS + 6) ?
                      SAT_FRAC_BITS + 1 : HUE_FRAC_BITS + 6;
  localparam int HW = $clog2((DEG_FULL << HUE_FRAC_BITS) + 1) + 1;
  localparam logic signed [HW-1:0] OFF_GREEN = HW'(DEG_GREEN << HUE_FRAC_BITS);
  localparam logic signed [HW-1:0] OFF_BLUE  = HW'(DEG_BLUE << HUE_FRAC_BITS);
  localparam logic signed [HW-1:0] OFF_FULL  = HW'(DEG_FULL << HUE_FRAC_BITS);

  side_t         st_side [QW+1];
  logic [7:0]    st_den_s [QW+1];
  logic [7:0]    st_rem_s [QW+1];
  logic [QW-1:0] st_nq_s [QW+1];
  logic [7:0]    st_den_h [QW+1];
  logic [7:0]    st_rem_h [QW+1];
  logic [QW-1:0] st_nq_h [QW+1];

  assign busy = 1'b0;

  rhsv_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS),
    .QW           (QW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (start && !busy),
    .pixel   (pixel),
    .side_out(st_side[0]),
    .den_s   (st_den_s[0]),
    .rem_s   (st_rem_s[0]),
    .nq_s    (st_nq_s[0]),
    .den_h   (st_den_h[0]),
    .rem_h   (st_rem_h[0]),
    .nq_h    (st_nq_h[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhsv_div_cell #(
      .QW(QW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (st_side[i]),
      .den_s_in (st_den_s[i]),
      .rem_s_in (st_rem_s[i]),
      .nq_s_in  (st_nq_s[i]),
      .den_h_in (st_den_h[i]),
      .rem_h_in (st_rem_h[i]),
      .nq_h_in  (st_nq_h[i]),
      .side_out (st_side[i+1]),
      .den_s_out(st_den_s[i+1]),
      .rem_s_out(st_rem_s[i+1]),
      .nq_s_out (st_nq_s[i+1]),
      .den_h_out(st_den_h[i+1]),
      .rem_h_out(st_rem_h[i+1]),
      .nq_h_out (st_nq_h[i+1])
    );
  end

  side_t                  fin;
  logic signed [HW-1:0]   offset, q_signed, hue_sum, hue_fix;
  result_t                result_next;

  assign fin = st_side[QW];

  always_comb begin
    unique case (fin.sector)
      SECT_RED:   offset = '0;
      SECT_GREEN: offset = OFF_GREEN;
      SECT_BLUE:  offset = OFF_BLUE;
      default:    offset = '0;
    endcase
    q_signed = signed'(HW'(st_nq_h[QW]));
    hue_sum  = fin.neg ? offset - q_signed : offset + q_signed;
    hue_fix  = (hue_sum < 0) ? hue_sum + OFF_FULL : hue_sum;
    result_next.hue_x64   = fin.grey ? 15'd0 : 15'(hue_fix);
    result_next.sat_frac  = fin.black ? 17'd0 : 17'(st_nq_s[QW]);
    result_next.value_out = fin.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

[rtl/core/rhsv_front.sv]
// rhsv_front: max/min search, sector pick and divider operand setup
// depends on rhsv_pkg; feeds the first rhsv_div_cell
`timescale 1ns / 1ps

module rhsv_front #(
  parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhsv_pkg::SAT_FRAC_BITS_DEF,
  parameter int QW            = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rhsv_pkg::pixel_t pixel,
  output rhsv_pkg::side_t side_out,
  output logic [7:0]      den_s,
  output logic [7:0]      rem_s,
  output logic [QW-1:0]   nq_s,
  output logic [7:0]      den_h,
  output logic [7:0]      rem_h,
  output logic [QW-1:0]   nq_h
);
  import rhsv_pkg::*;

  localparam int NW = QW + 8;

  logic [7:0]    r, g, b;
  logic [7:0]    mx, mn, delta, mag;
  logic [8:0]    diff;
  sector_t       sector;
  logic [13:0]   mag60;
  logic [NW-1:0] num_s, num_h;

  assign r = pixel.red_in;
  assign g = pixel.green_in;
  assign b = pixel.blue_in;

  always_comb begin
    // ties go to red, then green
    priority if (r >= g && r >= b) begin
      sector = SECT_RED;
      mx     = r;
      diff   = {1'b0, g} - {1'b0, b};
    end else if (g >= b) begin
      sector = SECT_GREEN;
      mx     = g;
      diff   = {1'b0, b} - {1'b0, r};
    end else begin
      sector = SECT_BLUE;
      mx     = b;
      diff   = {1'b0, r} - {1'b0, g};
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    mag   = diff[8] ? 8'(-diff) : diff[7:0];
    mag60 = 14'(mag) * 14'(DEG_SECTOR);
    num_s = NW'(delta) << SAT_FRAC_BITS;
    num_h = NW'(mag60) << HUE_FRAC_BITS;
  end

  // quotient fits in QW bits, so the top bits of each numerator start as remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= take;
    end
    side_out.value  <= mx;
    side_out.sector <= sector;
    side_out.neg    <= diff[8];
    side_out.grey   <= (delta == 8'd0);
    side_out.black  <= (mx == 8'd0);
    den_s <= mx;
    rem_s <= num_s[NW-1:QW];
    nq_s  <= num_s[QW-1:0];
    den_h <= delta;
    rem_h <= num_h[NW-1:QW];
    nq_h  <= num_h[QW-1:0];
  end

endmodule

[rtl/core/rhsv_div_cell.sv]
// rhsv_div_cell: one restoring-division step for both the saturation and hue quotients
// depends on rhsv_pkg; chained QW deep by the top level
`timescale 1ns / 1ps

module rhsv_div_cell #(
  parameter int QW = 17
) (
  input  logic            clk,
  input  logic            rst,
  input  rhsv_pkg::side_t side_in,
  input  logic [7:0]      den_s_in,
  input  logic [7:0]      rem_s_in,
  input  logic [QW-1:0]   nq_s_in,
  input  logic [7:0]      den_h_in,
  input  logic [7:0]      rem_h_in,
  input  logic [QW-1:0]   nq_h_in,
  output rhsv_pkg::side_t side_out,
  output logic [7:0]      den_s_out,
  output logic [7:0]      rem_s_out,
  output logic [QW-1:0]   nq_s_out,
  output logic [7:0]      den_h_out,
  output logic [7:0]      rem_h_out,
  output logic [QW-1:0]   nq_h_out
);
  import rhsv_pkg::*;

  logic [8:0] trial_s, trial_h, diff_s, diff_h;
  logic       ge_s, ge_h;

  always_comb begin
    trial_s = {rem_s_in, nq_s_in[QW-1]};
    trial_h = {rem_h_in, nq_h_in[QW-1]};
    diff_s  = trial_s - {1'b0, den_s_in};
    diff_h  = trial_h - {1'b0, den_h_in};
    ge_s    = (trial_s >= {1'b0, den_s_in});
    ge_h    = (trial_h >= {1'b0, den_h_in});
  end

  // numerator bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.value  <= side_in.value;
    side_out.sector <= side_in.sector;
    side_out.neg    <= side_in.neg;
    side_out.grey   <= side_in.grey;
    side_out.black  <= side_in.black;
    den_s_out <= den_s_in;
    den_h_out <= den_h_in;
    rem_s_out <= ge_s ? diff_s[7:0] : trial_s[7:0];
    rem_h_out <= ge_h ? diff_h[7:0] : trial_h[7:0];
    nq_s_out  <= {nq_s_in[QW-2:0], ge_s};
    nq_h_out  <= {nq_h_in[QW-2:0], ge_h};
  end

endmodule

[dv/rgb_to_hsv_converter_tb.sv]
// rgb_to_hsv_converter_tb: self-checking bench for the pixel-rate rgb to hsv converter
// depends on rhsv_pkg and rgb_to_hsv_converter; predicts hue, saturation and value per pixel
`timescale 1ns / 1ps

module rgb_to_hsv_converter_tb;
  import rhsv_pkg::*;

  localparam int HUE_FRAC   = HUE_FRAC_BITS_DEF;
  localparam int SAT_FRAC   = SAT_FRAC_BITS_DEF;
  localparam int PIPE_LAT   = ((SAT_FRAC + 1) > (HUE_FRAC + 6) ? SAT_FRAC + 1 : HUE_FRAC + 6) + 2;
  localparam int MAX_GAP    = 20;
  localparam int STALL_LIMIT = 500;
  localparam int RAND_PIXELS = 850;

  class hsv_scoreboard;
    result_t pending[$];
    int      errors;
    int      noted;
    int      checked;

    // 60 degrees scaled by the hue fraction times diff/delta, truncated toward zero
    static function int sixty_part(int diff, int delta);
      int mag;
      int q;
      mag = (diff < 0) ? -diff : diff;
      q = (mag * (DEG_SECTOR << HUE_FRAC)) / delta;
      return (diff < 0) ? -q : q;
    endfunction

    static function result_t hsv_of(pixel_t px);
      result_t res;
      int r, g, b, mx, mn, delta, hue, sat;
      r = px.red_in;
      g = px.green_in;
      b = px.blue_in;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      sat = (mx != 0) ? (delta << SAT_FRAC) / mx : 0;
      hue = 0;
      if (delta != 0) begin
        // ties on the max go to red, then green
        if (mx == r) hue = sixty_part(g - b, delta);
        else if (mx == g) hue = (DEG_GREEN << HUE_FRAC) + sixty_part(b - r, delta);
        else hue = (DEG_BLUE << HUE_FRAC) + sixty_part(r - g, delta);
        if (hue < 0) hue += DEG_FULL << HUE_FRAC;
      end
      res.hue_x64   = hue[14:0];
      res.sat_frac  = sat[16:0];
      res.value_out = mx[7:0];
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      pending.push_back(hsv_of(px));
      noted++;
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected result, hue", got.hue_x64, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.hue_x64 !== want.hue_x64) report("hue_x64", got.hue_x64, want.hue_x64);
      if (got.sat_frac !== want.sat_frac) report("sat_frac", got.sat_frac, want.sat_frac);
      if (got.value_out !== want.value_out) report("value_out", got.value_out, want.value_out);
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  pixel_t  pix;
  logic    done;
  result_t res;

  hsv_scoreboard sb;
  int idle_cycles;
  int idle_pct;

  rgb_to_hsv_converter uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pix),
    .done   (done),
    .result (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // accepted beats on both sides feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_pixel(pix);
      if (done) sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("[rgb_to_hsv_converter] ERROR");
        $finish;
      end
    end
  end

  // idle gap drawn from the current phase, then one beat held until taken
  task send_pixel(pixel_t px);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    pix   <= px;
    do @(posedge clk); while (busy);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    logic [7:0] a, c;
    px = pixel_t'($urandom);
    a = 8'($urandom);
    c = 8'($urandom_range(255, a));
    case ($urandom_range(9))
      6: px = '{a, a, a};
      7: begin
        // two channels share the max
        case ($urandom_range(2))
          0: px = '{c, c, a};
          1: px = '{a, c, c};
          default: px = '{c, a, c};
        endcase
      end
      8: begin
        if ($urandom_range(1)) px.red_in = 8'hff; else px.green_in = 8'h00;
        if ($urandom_range(1)) px.blue_in = 8'hff; else px.blue_in = 8'h00;
      end
      9: px = '{8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    pixel_t directed[$];
    sb = new();
    rst      = 1'b1;
    start    = 1'b0;
    pix      = '0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed = '{
      '{8'd0, 8'd0, 8'd0},       '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd255, 8'd0, 8'd0},     '{8'd0, 8'd255, 8'd0},     '{8'd0, 8'd0, 8'd255},
      '{8'd255, 8'd255, 8'd0},   '{8'd0, 8'd255, 8'd255},   '{8'd255, 8'd0, 8'd255},
      '{8'd255, 8'd0, 8'd1},     '{8'd255, 8'd0, 8'd254},   '{8'd1, 8'd0, 8'd0},
      '{8'd255, 8'd254, 8'd0},   '{8'd0, 8'd1, 8'd255},     '{8'd254, 8'd255, 8'd255},
      '{8'd1, 8'd1, 8'd0},       '{8'd0, 8'd1, 8'd1},       '{8'd1, 8'd0, 8'd1},
      '{8'd170, 8'd85, 8'd0},    '{8'd0, 8'd85, 8'd170},    '{8'd85, 8'd0, 8'd170},
      '{8'd1, 8'd255, 8'd2}
    };
    foreach (directed[i]) send_pixel(directed[i]);

    // pacing phases: back to back, sparse, back to back again, moderate
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 54;
        3: idle_pct = 31;
        default: idle_pct = 0;
      endcase
      repeat (RAND_PIXELS / 4) send_pixel(rand_pixel());
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);

    $display("run covered %0d pixels (directed extremes, ties, greys, random) in four phases",
             sb.noted);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[rgb_to_hsv_converter] OK");
    end else begin
      $display("[rgb_to_hsv_converter] ERROR");
    end
    $finish;
  end

endmodule
